// ===== hdl/kvp_pkg.sv =====
// ----------------------------------------------------------------------------
// kvp_pkg: shared types and constants of the get/set text parser
// Byte class word handed from the front end to the execute stage, result
// word, status and command codes, character codes and hash constants.
// ----------------------------------------------------------------------------
`default_nettype none

package kvp_pkg;

  typedef enum logic [1:0] {
    ST_CONT = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2,
    ST_OVFL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_UNKNOWN = 2'd0,
    CMD_GET     = 2'd1,
    CMD_SET     = 2'd2
  } cmd_e;

  localparam logic [7:0] CH_G_UP  = 8'h47;
  localparam logic [7:0] CH_G_LO  = 8'h67;
  localparam logic [7:0] CH_S_UP  = 8'h53;
  localparam logic [7:0] CH_S_LO  = 8'h73;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [7:0] SEP_MAX = 8'd255;
  localparam logic [7:0] SET_END = 8'd5;

  localparam int unsigned KEY_LEN_W = 9;
  localparam int unsigned VAL_LEN_W = 11;

  // one classified request byte
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       is_get;
    logic       is_set;
    logic       is_space;
    logic       is_cr;
    logic       is_lf;
  } front_word_t;

  // one result word
  typedef struct packed {
    status_e              status;
    cmd_e                 command;
    logic [31:0]          key_hash;
    logic [KEY_LEN_W-1:0] key_length;
    logic [VAL_LEN_W-1:0] value_length;
    logic                 key_write;
    logic                 value_write;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/kvp_front.sv =====
// ----------------------------------------------------------------------------
// kvp_front: byte classifier
// Decodes command letters and separators of each incoming byte so the
// execute stage gets single-bit classes beside the byte itself.
// ----------------------------------------------------------------------------
`default_nettype none

module kvp_front (
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         in_data_i,
  input  wire logic               in_restart_i,
  output logic                    in_ready_o,
  output logic                    push_o,
  output kvp_pkg::front_word_t    word_o,
  input  wire logic               queue_full_i
);

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    word_o.data     = in_data_i;
    word_o.restart  = in_restart_i;
    word_o.is_get   = (in_data_i == kvp_pkg::CH_G_UP) || (in_data_i == kvp_pkg::CH_G_LO);
    word_o.is_set   = (in_data_i == kvp_pkg::CH_S_UP) || (in_data_i == kvp_pkg::CH_S_LO);
    word_o.is_space = (in_data_i == kvp_pkg::CH_SPACE);
    word_o.is_cr    = (in_data_i == kvp_pkg::CH_CR);
    word_o.is_lf    = (in_data_i == kvp_pkg::CH_LF);
  end

endmodule

`default_nettype wire

// ===== hdl/kvp_queue.sv =====
// ----------------------------------------------------------------------------
// kvp_queue: two-entry word queue
// Decouples the classifier from the execute stage; full throughput with
// simultaneous push and pop.
// ----------------------------------------------------------------------------
`default_nettype none

module kvp_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire kvp_pkg::front_word_t push_word_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output kvp_pkg::front_word_t      pop_word_o
);

  kvp_pkg::front_word_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_word_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kvp_back.sv =====
// ----------------------------------------------------------------------------
// kvp_back: parser execute stage
// Runs the command/key/value FSM one word per cycle unless stalled, writes the
// key and value stores, updates the FNV-1a hash and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module kvp_back #(
  parameter int unsigned KEY_DEPTH   = 256,
  parameter int unsigned VALUE_DEPTH = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 word_valid_i,
  input  wire kvp_pkg::front_word_t word_i,
  output logic                      pop_o,
  output logic                      res_valid_o,
  output kvp_pkg::result_t          res_o,
  input  wire logic                 res_ready_i
);

  localparam int unsigned KCW = $clog2(KEY_DEPTH + 1);
  localparam int unsigned VCW = $clog2(VALUE_DEPTH + 1);
  localparam int unsigned KAW = $clog2(KEY_DEPTH);
  localparam int unsigned VAW = $clog2(VALUE_DEPTH);
  localparam logic [KCW-1:0] KEY_FULL = KCW'(KEY_DEPTH);
  localparam logic [VCW-1:0] VAL_FULL = VCW'(VALUE_DEPTH);

  localparam logic PH_CMD = 1'b0;
  localparam logic PH_KEY = 1'b1;

  logic            phase_q, phase_d;
  logic [7:0]      sep_q, sep_d;
  kvp_pkg::cmd_e   cmd_q, cmd_d;
  logic [KCW-1:0]  kcnt_q, kcnt_d;
  logic [VCW-1:0]  vcnt_q, vcnt_d;
  logic [31:0]     hash_q, hash_d;

  logic [7:0]      key_mem_q [KEY_DEPTH];
  logic [7:0]      val_mem_q [VALUE_DEPTH];

  logic            res_valid_q, res_valid_d;
  kvp_pkg::result_t res_q, res_d;

  // state as seen by this word, after an optional restart
  logic            cur_phase;
  logic [7:0]      cur_sep;
  kvp_pkg::cmd_e   cur_cmd;
  logic [KCW-1:0]  cur_kcnt;
  logic [VCW-1:0]  cur_vcnt;
  logic [31:0]     cur_hash;

  logic [31:0]     hash_base;
  logic [31:0]     hash_mix;
  logic [31:0]     hash_prod;
  logic [7:0]      sep_sp;
  logic [7:0]      sep_lf;
  logic            want_key, want_val;
  logic            key_we, val_we;
  kvp_pkg::status_e status;
  logic [KCW+kvp_pkg::KEY_LEN_W-1:0] kcnt_ext;
  logic [VCW+kvp_pkg::VAL_LEN_W-1:0] vcnt_ext;

  assign pop_o = word_valid_i && (!res_valid_q || res_ready_i);

  always_comb begin
    if (word_i.restart) begin
      cur_phase = PH_CMD;
      cur_sep   = 8'd0;
      cur_cmd   = kvp_pkg::CMD_UNKNOWN;
      cur_kcnt  = '0;
      cur_vcnt  = '0;
      cur_hash  = '0;
    end else begin
      cur_phase = phase_q;
      cur_sep   = sep_q;
      cur_cmd   = cmd_q;
      cur_kcnt  = kcnt_q;
      cur_vcnt  = vcnt_q;
      cur_hash  = hash_q;
    end
  end

  // hash update: one constant multiply per key byte, byte sign-extended
  assign hash_base = (cur_kcnt == '0) ? kvp_pkg::FNV_BASIS : cur_hash;
  assign hash_mix  = hash_base ^ {{24{word_i.data[7]}}, word_i.data};
  assign hash_prod = hash_mix * kvp_pkg::FNV_PRIME;

  always_comb begin
    phase_d  = cur_phase;
    sep_d    = cur_sep;
    cmd_d    = cur_cmd;
    kcnt_d   = cur_kcnt;
    vcnt_d   = cur_vcnt;
    hash_d   = cur_hash;
    status   = kvp_pkg::ST_CONT;
    want_key = 1'b0;
    want_val = 1'b0;
    key_we   = 1'b0;
    val_we   = 1'b0;
    sep_sp   = cur_sep;
    sep_lf   = cur_sep;

    unique case (cur_phase)
      PH_CMD: begin
        if (cur_sep == 8'd0) begin
          if (word_i.is_get) begin
            cmd_d = kvp_pkg::CMD_GET;
            sep_d = 8'd1;
          end else if (word_i.is_set) begin
            cmd_d = kvp_pkg::CMD_SET;
            sep_d = 8'd1;
          end else begin
            status = kvp_pkg::ST_BAD;
          end
        end else if (cur_sep == 8'd1) begin
          if (word_i.is_space) begin
            sep_d   = 8'd0;
            phase_d = PH_KEY;
          end
        end else begin
          status = kvp_pkg::ST_BAD;
        end
      end
      PH_KEY: begin
        hash_d = hash_base;
        if ((cur_cmd == kvp_pkg::CMD_GET) && (cur_sep == 8'd0)) begin
          if (word_i.is_space || word_i.is_cr) begin
            status = kvp_pkg::ST_DONE;
          end else begin
            want_key = 1'b1;
          end
        end else if (cur_cmd == kvp_pkg::CMD_SET) begin
          if (word_i.is_space && (cur_sep != kvp_pkg::SEP_MAX)) begin
            sep_sp = cur_sep + 8'd1;
          end
          sep_d = sep_sp;
          if (sep_sp != 8'd2) begin
            want_key = (sep_sp == 8'd0);
            want_val = 1'b1;
          end
        end else begin
          status = kvp_pkg::ST_BAD;
        end

        if ((want_key && (cur_kcnt >= KEY_FULL)) || (want_val && (cur_vcnt >= VAL_FULL))) begin
          status = kvp_pkg::ST_OVFL;
        end else begin
          if (want_key) begin
            key_we = 1'b1;
            kcnt_d = cur_kcnt + KCW'(1);
            hash_d = hash_prod;
          end
          if (want_val) begin
            val_we = 1'b1;
            vcnt_d = cur_vcnt + VCW'(1);
            if (word_i.is_lf) begin
              sep_lf = (sep_sp != kvp_pkg::SEP_MAX) ? sep_sp + 8'd1 : sep_sp;
              sep_d  = sep_lf;
              if (sep_lf == kvp_pkg::SET_END) begin
                status = kvp_pkg::ST_DONE;
              end
            end
          end
        end
      end
      default: begin
        status = kvp_pkg::ST_BAD;
      end
    endcase
  end

  assign kcnt_ext = {{kvp_pkg::KEY_LEN_W{1'b0}}, kcnt_d};
  assign vcnt_ext = {{kvp_pkg::VAL_LEN_W{1'b0}}, vcnt_d};

  always_comb begin
    res_d.status       = status;
    res_d.command      = cmd_d;
    res_d.key_hash     = hash_d;
    res_d.key_length   = kcnt_ext[kvp_pkg::KEY_LEN_W-1:0];
    res_d.value_length = vcnt_ext[kvp_pkg::VAL_LEN_W-1:0];
    res_d.key_write    = key_we;
    res_d.value_write  = val_we;
    if (pop_o) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CMD;
      sep_q       <= 8'd0;
      cmd_q       <= kvp_pkg::CMD_UNKNOWN;
      kcnt_q      <= '0;
      vcnt_q      <= '0;
      hash_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (pop_o) begin
        // any nonzero status ends the request
        if (status != kvp_pkg::ST_CONT) begin
          phase_q <= PH_CMD;
          sep_q   <= 8'd0;
          cmd_q   <= kvp_pkg::CMD_UNKNOWN;
          kcnt_q  <= '0;
          vcnt_q  <= '0;
          hash_q  <= '0;
        end else begin
          phase_q <= phase_d;
          sep_q   <= sep_d;
          cmd_q   <= cmd_d;
          kcnt_q  <= kcnt_d;
          vcnt_q  <= vcnt_d;
          hash_q  <= hash_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && key_we) begin
      key_mem_q[cur_kcnt[KAW-1:0]] <= word_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && val_we) begin
      val_mem_q[cur_vcnt[VAW-1:0]] <= word_i.data;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== hdl/kv_text_command_parser.sv =====
// ----------------------------------------------------------------------------
// kv_text_command_parser: streaming get/set request parser
// Takes one request byte per word, tracks command, key and value phases,
// hashes the key (FNV-1a, 32 bit) and reports one status word per byte.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                          tuser
//  s_axis   in   [7:0] data_byte                [0] restart
//  m_axis   out  [31:0] key_hash, [40:32]       [1:0] status, [3:2] command
//                key_length, [51:41] value_len,
//                [52] key_write, [53] value_write
//
// Rate: one word in and one word out per clock sustained while m_axis_tready_i
//   stays high; each result passes the queue slot, then the result register.
// The hash loop does one 32-bit constant multiply per key byte.
// Reset: rst_ni clears parser state, queue and result valid; the stores hold
//   no reset and are only written.
// Stalls: a two-word queue lets the input keep flowing while the result
//   register waits; s_axis_tready_o drops only when the queue is full.
//
`default_nettype none

module kv_text_command_parser #(
  parameter int unsigned KEY_DEPTH   = 256,
  parameter int unsigned VALUE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] restart
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [55:0]      m_axis_tdata_o,   // [31:0] key_hash, [40:32] key_length,
                                             // [51:41] value_length, [52] key_write,
                                             // [53] value_write, [55:54] zero
  output logic [3:0]       m_axis_tuser_o    // [1:0] status, [3:2] command
);

  kvp_pkg::front_word_t fr_word;
  kvp_pkg::front_word_t q_word;
  kvp_pkg::result_t     res;
  logic fr_push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  // classify each byte on the way in
  kvp_front u_front (
    .in_valid_i   (s_axis_tvalid_i),
    .in_data_i    (s_axis_tdata_i),
    .in_restart_i (s_axis_tuser_i[0]),
    .in_ready_o   (s_axis_tready_o),
    .push_o       (fr_push),
    .word_o       (fr_word),
    .queue_full_i (q_full)
  );

  kvp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_push),
    .push_word_i (fr_word),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_word_o  (q_word)
  );

  kvp_back #(
    .KEY_DEPTH   (KEY_DEPTH),
    .VALUE_DEPTH (VALUE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (q_valid),
    .word_i       (q_word),
    .pop_o        (q_pop),
    .res_valid_o  (m_axis_tvalid_o),
    .res_o        (res),
    .res_ready_i  (m_axis_tready_i)
  );

  // pack result word onto the master side
  assign m_axis_tdata_o = {2'b00, res.value_write, res.key_write, res.value_length,
                           res.key_length, res.key_hash};
  assign m_axis_tuser_o = {res.command, res.status};

`ifndef SYNTHESIS
  // a stored key byte never comes with an error status
  a_kw_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res.key_write) |->
      (res.status != kvp_pkg::ST_OVFL) && (res.status != kvp_pkg::ST_BAD))
    else $error("key write reported with error status");

  // completion needs a known command
  a_done_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (res.status == kvp_pkg::ST_DONE)) |->
      (res.command != kvp_pkg::CMD_UNKNOWN))
    else $error("request complete without command");

  // value bytes are only stored for a set
  a_vw_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res.value_write) |-> (res.command == kvp_pkg::CMD_SET))
    else $error("value write outside set");

  // a queue pop with the result stalled would drop a word
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !q_pop)
    else $error("execute stage advanced while result stalled");
`endif

endmodule

`default_nettype wire

// ===== bench/kv_parse_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kv_parse_checker: result prediction and comparison for the request parser
// Follows each word taken on the input channel through its own copy of the
// parser state, queues the predicted result word and compares every word
// taken on the output channel field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module kv_parse_checker #(
  parameter int unsigned KEY_DEPTH   = 256,
  parameter int unsigned VALUE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,
  input  logic [0:0]  in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [55:0] out_data_i,
  input  logic [3:0]  out_user_i,
  output int          fail_count_o,
  output int          open_count_o,
  output int          word_count_o,
  output int          done_count_o,
  output int          bad_count_o,
  output int          ovfl_count_o
);

  // only the first mismatches are printed, all are counted
  localparam int PRINT_LIMIT = 100;

  logic              in_key;
  logic [7:0]        sep_cnt;
  kvp_pkg::cmd_e     cmd_kind;
  int unsigned       key_cnt;
  int unsigned       val_cnt;
  logic [31:0]       hash;
  kvp_pkg::result_t  parsed_q[$];

  function automatic void clear_parse();
    in_key   = 1'b0;
    sep_cnt  = '0;
    cmd_kind = kvp_pkg::CMD_UNKNOWN;
    key_cnt  = 0;
    val_cnt  = 0;
    hash     = '0;
  endfunction

  function automatic void bump_sep();
    if (sep_cnt != kvp_pkg::SEP_MAX) sep_cnt++;
  endfunction

  // next parser state and result word for one request byte
  function automatic kvp_pkg::result_t parse_byte(input logic [7:0] b, input logic restart);
    kvp_pkg::result_t res;
    kvp_pkg::status_e st;
    logic    to_key;
    logic    to_val;
    logic    key_wr;
    logic    val_wr;
    st     = kvp_pkg::ST_CONT;
    to_key = 1'b0;
    to_val = 1'b0;
    key_wr = 1'b0;
    val_wr = 1'b0;
    if (restart) clear_parse();
    if (!in_key) begin
      if (sep_cnt == 0) begin
        if (b == kvp_pkg::CH_G_UP || b == kvp_pkg::CH_G_LO) begin
          cmd_kind = kvp_pkg::CMD_GET;
          sep_cnt  = 8'd1;
        end else if (b == kvp_pkg::CH_S_UP || b == kvp_pkg::CH_S_LO) begin
          cmd_kind = kvp_pkg::CMD_SET;
          sep_cnt  = 8'd1;
        end else begin
          st = kvp_pkg::ST_BAD;
        end
      end else if (sep_cnt == 1) begin
        if (b == kvp_pkg::CH_SPACE) begin
          sep_cnt = '0;
          in_key  = 1'b1;
        end
      end else begin
        st = kvp_pkg::ST_BAD;
      end
    end else begin
      // hash is seeded on every key-phase byte while no key byte is stored
      if (key_cnt == 0) hash = kvp_pkg::FNV_BASIS;
      if (cmd_kind == kvp_pkg::CMD_GET && sep_cnt == 0) begin
        if (b == kvp_pkg::CH_SPACE || b == kvp_pkg::CH_CR) st = kvp_pkg::ST_DONE;
        else to_key = 1'b1;
      end else if (cmd_kind == kvp_pkg::CMD_SET) begin
        if (b == kvp_pkg::CH_SPACE) bump_sep();
        if (sep_cnt != 2) begin
          to_key = (sep_cnt == 0);
          to_val = 1'b1;
        end
      end else begin
        st = kvp_pkg::ST_BAD;
      end

      if ((to_key && key_cnt >= KEY_DEPTH) || (to_val && val_cnt >= VALUE_DEPTH)) begin
        st = kvp_pkg::ST_OVFL;
      end else begin
        if (to_key) begin
          key_cnt++;
          hash   = (hash ^ {{24{b[7]}}, b}) * kvp_pkg::FNV_PRIME;
          key_wr = 1'b1;
        end
        if (to_val) begin
          val_cnt++;
          val_wr = 1'b1;
          if (b == kvp_pkg::CH_LF) begin
            bump_sep();
            if (sep_cnt == kvp_pkg::SET_END) st = kvp_pkg::ST_DONE;
          end
        end
      end
    end

    res.status       = st;
    res.command      = cmd_kind;
    res.key_hash     = hash;
    res.key_length   = kvp_pkg::KEY_LEN_W'(key_cnt);
    res.value_length = kvp_pkg::VAL_LEN_W'(val_cnt);
    res.key_write    = key_wr;
    res.value_write  = val_wr;
    if (st != kvp_pkg::ST_CONT) clear_parse();
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      if (fail_count_o < PRINT_LIMIT)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kvp_pkg::result_t want;
    if (!rst_ni) begin
      clear_parse();
      parsed_q.delete();
      fail_count_o = 0;
      open_count_o = 0;
      word_count_o = 0;
      done_count_o = 0;
      bad_count_o  = 0;
      ovfl_count_o = 0;
    end else begin
      // compare before queuing: a word taken now cannot be the result of
      // a byte taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (parsed_q.size() == 0) begin
          if (fail_count_o < PRINT_LIMIT)
            $display("%0t: result word with none expected, tdata 0x%0h tuser 0x%0h",
                     $time, out_data_i, out_user_i);
          fail_count_o++;
        end else begin
          want = parsed_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_user_i[1:0]));
          check_field("command", 32'(want.command), 32'(out_user_i[3:2]));
          check_field("key_hash", want.key_hash, out_data_i[31:0]);
          check_field("key_length", 32'(want.key_length), 32'(out_data_i[40:32]));
          check_field("value_length", 32'(want.value_length), 32'(out_data_i[51:41]));
          check_field("key_write", 32'(want.key_write), 32'(out_data_i[52]));
          check_field("value_write", 32'(want.value_write), 32'(out_data_i[53]));
          word_count_o++;
          case (want.status)
            kvp_pkg::ST_DONE: done_count_o++;
            kvp_pkg::ST_BAD:  bad_count_o++;
            kvp_pkg::ST_OVFL: ovfl_count_o++;
            default: ;
          endcase
        end
      end
      if (in_valid_i && in_ready_i) parsed_q.push_back(parse_byte(in_data_i, in_user_i[0]));
      open_count_o = parsed_q.size();
    end
  end

endmodule

// ===== bench/kv_text_command_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kv_text_command_parser_tb: stimulus and verdict for the request parser
// Streams directed get/set requests, a key store overflow run and random well-
// formed, broken and noise requests into the parser with random gaps and
// output stalls; a checker beside the block predicts every result word.
// ----------------------------------------------------------------------------
module kv_text_command_parser_tb;

  localparam int unsigned KEY_DEPTH    = 256;
  localparam int unsigned VALUE_DEPTH  = 1024;
  localparam int          RANDOM_WORDS = 200;
  localparam int          SEP_SPACES   = 260;   // enough spaces to saturate the count
  localparam int          IDLE_LIMIT   = 1000;  // cycles with no word moving
  localparam int          TAIL_CYCLES  = 8;
  localparam int          DRAIN_EVERY  = 64;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [3:0]  m_tuser;

  int fail_count;
  int open_count;
  int word_count;
  int done_count;
  int bad_count;
  int ovfl_count;

  int words_sent  = 0;
  int src_max     = 0;
  int sink_max    = 0;
  int sink_hold   = 0;
  int idle_cycles = 0;
  logic result_taken = 1'b0;

  always #4 clk = ~clk;

  kv_text_command_parser #(
    .KEY_DEPTH   (KEY_DEPTH),
    .VALUE_DEPTH (VALUE_DEPTH)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  kv_parse_checker #(
    .KEY_DEPTH   (KEY_DEPTH),
    .VALUE_DEPTH (VALUE_DEPTH)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_tvalid),
    .in_ready_i   (s_tready),
    .in_data_i    (s_tdata),
    .in_user_i    (s_tuser),
    .out_valid_i  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_data_i   (m_tdata),
    .out_user_i   (m_tuser),
    .fail_count_o (fail_count),
    .open_count_o (open_count),
    .word_count_o (word_count),
    .done_count_o (done_count),
    .bad_count_o  (bad_count),
    .ovfl_count_o (ovfl_count)
  );

  // result side: after each word taken, stall for a drawn number of cycles
  always @(posedge clk) result_taken <= m_tvalid && m_tready;

  always @(negedge clk) begin
    if (result_taken) sink_hold = $urandom_range(0, sink_max);
    if (sink_hold != 0) begin
      m_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("** kv_text_command_parser: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // idle maxima: none, light or full, so busy stretches alternate with gaps
  function automatic int idle_pick();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      default: return 12;
    endcase
  endfunction

  // printable text mostly, any byte sometimes; never a space nor bar_a/bar_b
  function automatic logic [7:0] text_byte(input logic [7:0] bar_a, input logic [7:0] bar_b);
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(8'h21, 8'h7e));
    end while (b == kvp_pkg::CH_SPACE || b == bar_a || b == bar_b);
    return b;
  endfunction

  // one word on the request channel; called at a falling edge, returns at one.
  // tvalid is left high so back-to-back words need no second assignment.
  task automatic send_word(input logic [7:0] data, input logic restart);
    int gap;
    if (words_sent % 48 == 0) begin
      src_max  = idle_pick();
      sink_max = idle_pick();
    end
    gap = $urandom_range(0, src_max);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string txt, input logic first_restart);
    for (int i = 0; i < txt.len(); i++) send_word(txt[i], (i == 0) ? first_restart : 1'b0);
  endtask

  // hold the request side until every predicted result word has arrived
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (open_count != 0);
  endtask

  // "get <key>" ended by a space or a CR, with junk after the command letter
  task automatic send_get(input logic first_restart);
    int n;
    send_word($urandom_range(0, 1) ? kvp_pkg::CH_G_UP : kvp_pkg::CH_G_LO, first_restart);
    n = $urandom_range(0, 3);
    repeat (n) send_word(text_byte(kvp_pkg::CH_SPACE, kvp_pkg::CH_SPACE), 1'b0);
    send_word(kvp_pkg::CH_SPACE, 1'b0);
    n = $urandom_range(0, 12);
    repeat (n) send_word(text_byte(kvp_pkg::CH_CR, kvp_pkg::CH_CR), 1'b0);
    send_word($urandom_range(0, 1) ? kvp_pkg::CH_SPACE : kvp_pkg::CH_CR, 1'b0);
  endtask

  // "set <key> <f1> <f2> <f3>\r\n<value>\r\n": separators 1..3 are the spaces,
  // the two LFs bring the count to four and five; f2 may hold LFs (skipped)
  task automatic send_set(input logic first_restart);
    int n;
    send_word($urandom_range(0, 1) ? kvp_pkg::CH_S_UP : kvp_pkg::CH_S_LO, first_restart);
    n = $urandom_range(0, 3);
    repeat (n) send_word(text_byte(kvp_pkg::CH_SPACE, kvp_pkg::CH_SPACE), 1'b0);
    send_word(kvp_pkg::CH_SPACE, 1'b0);
    n = $urandom_range(0, 12);
    repeat (n) send_word(text_byte(kvp_pkg::CH_LF, kvp_pkg::CH_LF), 1'b0);
    send_word(kvp_pkg::CH_SPACE, 1'b0);
    n = $urandom_range(0, 3);
    repeat (n) send_word(text_byte(kvp_pkg::CH_LF, kvp_pkg::CH_LF), 1'b0);
    send_word(kvp_pkg::CH_SPACE, 1'b0);
    n = $urandom_range(0, 4);
    repeat (n) send_word($urandom_range(0, 2) == 0 ? kvp_pkg::CH_LF :
                         text_byte(kvp_pkg::CH_SPACE, kvp_pkg::CH_SPACE), 1'b0);
    send_word(kvp_pkg::CH_SPACE, 1'b0);
    n = $urandom_range(0, 3);
    repeat (n) send_word(text_byte(kvp_pkg::CH_LF, kvp_pkg::CH_LF), 1'b0);
    send_word(kvp_pkg::CH_CR, 1'b0);
    send_word(kvp_pkg::CH_LF, 1'b0);
    n = $urandom_range(0, 16);
    repeat (n) send_word(text_byte(kvp_pkg::CH_LF, kvp_pkg::CH_LF), 1'b0);
    send_word(kvp_pkg::CH_CR, 1'b0);
    send_word(kvp_pkg::CH_LF, 1'b0);
  endtask

  initial begin
    int   n;
    int   random_start;
    logic force_restart;
    force_restart = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: bad command bytes at both extremes
    send_word(8'h00, 1'b1);
    send_word(8'hff, 1'b0);
    // get with sign-extended key bytes, ended by a space
    send_text("G ", 1'b0);
    send_word(8'h7f, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(kvp_pkg::CH_SPACE, 1'b0);
    // get with an empty key, ended by CR: hash reads the seed
    send_text("get \r", 1'b0);
    // set: LF in the skipped field, a space reaching five, an LF past five
    send_text("s k  \n \r\n \n", 1'b0);
    // restart in the middle of a set, then in the middle of a key
    send_text("S", 1'b1);
    send_text(" a", 1'b0);
    send_text("g", 1'b1);
    wait_drained();

    // key store fills, the next key byte overflows
    send_word(kvp_pkg::CH_G_LO, 1'b1);
    send_word(kvp_pkg::CH_SPACE, 1'b0);
    repeat (KEY_DEPTH + 1) send_word(text_byte(kvp_pkg::CH_CR, kvp_pkg::CH_CR), 1'b0);
    // set of spaces: separator count saturates
    send_text("S k", 1'b1);
    repeat (SEP_SPACES) send_word(kvp_pkg::CH_SPACE, 1'b0);
    wait_drained();

    // random: mostly well-formed requests, some broken ones and noise
    force_restart = 1'b1;
    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      n = $urandom_range(0, 99);
      if (n < 40) begin
        send_get(force_restart || $urandom_range(0, 3) == 0);
        force_restart = 1'b0;
      end else if (n < 80) begin
        send_set(force_restart || $urandom_range(0, 3) == 0);
        force_restart = 1'b0;
      end else if (n < 90) begin
        // request cut short by garbage; the next one restarts the parser
        send_word(text_byte(kvp_pkg::CH_SPACE, kvp_pkg::CH_SPACE), 1'($urandom_range(0, 1)));
        n = $urandom_range(0, 6);
        repeat (n) send_word(8'($urandom_range(0, 255)), 1'b0);
        force_restart = 1'b1;
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      if ((words_sent - random_start) % DRAIN_EVERY < 12 && $urandom_range(0, 3) == 0)
        wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d request words (%0d random); checked %0d result words.",
             words_sent, words_sent - random_start, word_count);
    $display("Seen: %0d finished requests, %0d bad command bytes, %0d store overflows.",
             done_count, bad_count, ovfl_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("** kv_text_command_parser: PASSED **");
    end else begin
      $display("** kv_text_command_parser: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/kvp_pkg.sv
hdl/kvp_front.sv
hdl/kvp_queue.sv
hdl/kvp_back.sv
hdl/kv_text_command_parser.sv
bench/kv_parse_checker.sv
bench/kv_text_command_parser_tb.sv
